FILE: sv/fpt_pkg.sv
// package: shared types, codes, constants and functions of the framed packet transmitter
`default_nettype none

package fpt_pkg;

  localparam int QUEUE_DEPTH_DEF  = 256;
  localparam int PACKET_BYTES_DEF = 32;
  localparam int MAX_PAYLOAD_DEF  = 27;

  localparam logic [7:0] LOST_LIMIT_RST = 8'd150;
  localparam logic [7:0] SOF_BYTE       = 8'hAA;
  localparam logic [7:0] EOF_BYTE       = 8'hAD;
  localparam logic [7:0] CRC_POLY_REFL  = 8'h8C;
  localparam int         FRAME_OVERHEAD = 5;

  localparam int         HB_IDX_W   = 3;
  localparam logic [2:0] HEART_LAST = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [1:0] {
    CMD_FRAME_START = 2'd0,
    CMD_PAYLOAD     = 2'd1,
    CMD_SEND        = 2'd2,
    CMD_RADIO       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_FULL     = 2'd2,
    ST_SEQ      = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAIRED     = 1'b0,
    REG_LOST_LIMIT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    PUSH_SOF     = 3'd0,
    PUSH_LEN_HI  = 3'd1,
    PUSH_LEN_LO  = 3'd2,
    PUSH_PAYLOAD = 3'd3,
    PUSH_CRC     = 3'd4,
    PUSH_EOF     = 3'd5
  } push_t;

  typedef enum logic [1:0] {
    OUT_STATUS = 2'd0,
    OUT_HEART  = 2'd1,
    OUT_QUEUE  = 2'd2
  } out_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_WR_SOF,
    S_WR_LEN_HI,
    S_WR_LEN_LO,
    S_WR_PAY,
    S_WR_CRC,
    S_WR_EOF,
    S_STATUS,
    S_HEART,
    S_DRAIN_RD,
    S_DRAIN_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     capture;
    logic     push_en;
    push_t    push_sel;
    logic     open_frame;
    logic     pay_step;
    logic     close_frame;
    logic     set_status;
    status_t  status;
    logic     radio_update;
    logic     drain_load;
    logic     drain_read;
    logic     drain_next;
    logic     heart_clear;
    logic     heart_next;
    out_sel_t out_sel;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic frame_open;
    logic too_long;
    logic no_room;
    logic len_zero;
    logic left_one;
    logic paired;
    logic queue_empty;
    logic drain_last;
    logic heart_last;
  } dp_stat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] radio_byte;
    logic       last;
    logic       heartbeat;
    status_t    status;
    logic       signal_ok;
  } out_word_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] heart_byte(input logic [HB_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hA1;
      3'd1:    b = 8'hB1;
      3'd2:    b = 8'hC2;
      3'd3:    b = 8'hD1;
      3'd4:    b = 8'hE1;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fpt_if.sv
// interfaces: input, result and configuration channels
`default_nettype none

interface fpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] frame_length;
  logic [7:0] payload_byte;
  logic       tx_ok;

  modport source(output valid, cmd, frame_length, payload_byte, tx_ok, input ready);
  modport sink(input valid, cmd, frame_length, payload_byte, tx_ok, output ready);
endinterface

interface fpt_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] radio_byte;
  logic       last;
  logic       heartbeat;
  logic [1:0] status;
  logic       signal_ok;

  modport source(output valid, kind, radio_byte, last, heartbeat, status, signal_ok,
                 input ready);
  modport sink(input valid, kind, radio_byte, last, heartbeat, status, signal_ok,
               output ready);
endinterface

interface fpt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpt_pkg::CFG_IDX_W-1:0]  index;
  logic [fpt_pkg::CFG_DAT_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/fpt_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none

module fpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/fpt_ctrl.sv
// controller: sequencing state machine of the framed packet transmitter
`default_nettype none

module fpt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire fpt_pkg::dp_stat_t stat,
  output fpt_pkg::dp_cmd_t       cmd
);

  fpt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fpt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = fpt_pkg::S_DECODE;
      end
      fpt_pkg::S_DECODE: begin
        unique case (stat.cmd)
          fpt_pkg::CMD_FRAME_START: begin
            if (stat.frame_open || stat.too_long || stat.no_room) begin
              state_nxt = fpt_pkg::S_STATUS;
            end else begin
              state_nxt = fpt_pkg::S_WR_SOF;
            end
          end
          fpt_pkg::CMD_PAYLOAD: begin
            state_nxt = stat.frame_open ? fpt_pkg::S_WR_PAY : fpt_pkg::S_STATUS;
          end
          fpt_pkg::CMD_SEND: begin
            if (!stat.paired) begin
              state_nxt = fpt_pkg::S_IDLE;
            end else if (stat.queue_empty) begin
              state_nxt = fpt_pkg::S_HEART;
            end else begin
              state_nxt = fpt_pkg::S_DRAIN_RD;
            end
          end
          fpt_pkg::CMD_RADIO: begin
            state_nxt = fpt_pkg::S_STATUS;
          end
          default: state_nxt = fpt_pkg::S_IDLE;
        endcase
      end
      fpt_pkg::S_WR_SOF:    state_nxt = fpt_pkg::S_WR_LEN_HI;
      fpt_pkg::S_WR_LEN_HI: state_nxt = fpt_pkg::S_WR_LEN_LO;
      fpt_pkg::S_WR_LEN_LO: begin
        state_nxt = stat.len_zero ? fpt_pkg::S_WR_CRC : fpt_pkg::S_STATUS;
      end
      fpt_pkg::S_WR_PAY: begin
        state_nxt = stat.left_one ? fpt_pkg::S_WR_CRC : fpt_pkg::S_STATUS;
      end
      fpt_pkg::S_WR_CRC: state_nxt = fpt_pkg::S_WR_EOF;
      fpt_pkg::S_WR_EOF: state_nxt = fpt_pkg::S_STATUS;
      fpt_pkg::S_STATUS: begin
        if (out_ready) state_nxt = fpt_pkg::S_IDLE;
      end
      fpt_pkg::S_HEART: begin
        if (out_ready && stat.heart_last) state_nxt = fpt_pkg::S_IDLE;
      end
      fpt_pkg::S_DRAIN_RD: state_nxt = fpt_pkg::S_DRAIN_OUT;
      fpt_pkg::S_DRAIN_OUT: begin
        if (out_ready) begin
          state_nxt = stat.drain_last ? fpt_pkg::S_IDLE : fpt_pkg::S_DRAIN_RD;
        end
      end
      default: state_nxt = fpt_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.push_sel = fpt_pkg::PUSH_SOF;
    cmd.status   = fpt_pkg::ST_OK;
    cmd.out_sel  = fpt_pkg::OUT_STATUS;
    unique case (state_r)
      fpt_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      fpt_pkg::S_DECODE: begin
        cmd.set_status  = 1'b1;
        cmd.heart_clear = 1'b1;
        unique case (stat.cmd)
          fpt_pkg::CMD_FRAME_START: begin
            if (stat.frame_open) begin
              cmd.status = fpt_pkg::ST_SEQ;
            end else if (stat.too_long) begin
              cmd.status = fpt_pkg::ST_TOO_LONG;
            end else if (stat.no_room) begin
              cmd.status = fpt_pkg::ST_FULL;
            end
          end
          fpt_pkg::CMD_PAYLOAD: begin
            if (!stat.frame_open) cmd.status = fpt_pkg::ST_SEQ;
          end
          fpt_pkg::CMD_SEND: begin
            cmd.drain_load = stat.paired && !stat.queue_empty;
          end
          fpt_pkg::CMD_RADIO: begin
            cmd.radio_update = 1'b1;
          end
          default: cmd.status = fpt_pkg::ST_OK;
        endcase
      end
      fpt_pkg::S_WR_SOF: begin
        cmd.push_en    = 1'b1;
        cmd.push_sel   = fpt_pkg::PUSH_SOF;
        cmd.open_frame = 1'b1;
      end
      fpt_pkg::S_WR_LEN_HI: begin
        cmd.push_en  = 1'b1;
        cmd.push_sel = fpt_pkg::PUSH_LEN_HI;
      end
      fpt_pkg::S_WR_LEN_LO: begin
        cmd.push_en  = 1'b1;
        cmd.push_sel = fpt_pkg::PUSH_LEN_LO;
      end
      fpt_pkg::S_WR_PAY: begin
        cmd.push_en  = 1'b1;
        cmd.push_sel = fpt_pkg::PUSH_PAYLOAD;
        cmd.pay_step = 1'b1;
      end
      fpt_pkg::S_WR_CRC: begin
        cmd.push_en  = 1'b1;
        cmd.push_sel = fpt_pkg::PUSH_CRC;
      end
      fpt_pkg::S_WR_EOF: begin
        cmd.push_en     = 1'b1;
        cmd.push_sel    = fpt_pkg::PUSH_EOF;
        cmd.close_frame = 1'b1;
      end
      fpt_pkg::S_STATUS: begin
        out_valid   = 1'b1;
        cmd.out_sel = fpt_pkg::OUT_STATUS;
      end
      fpt_pkg::S_HEART: begin
        out_valid      = 1'b1;
        cmd.out_sel    = fpt_pkg::OUT_HEART;
        cmd.heart_next = out_ready;
      end
      fpt_pkg::S_DRAIN_RD: begin
        cmd.drain_read = 1'b1;
      end
      fpt_pkg::S_DRAIN_OUT: begin
        out_valid      = 1'b1;
        cmd.out_sel    = fpt_pkg::OUT_QUEUE;
        cmd.drain_next = out_ready;
      end
      default: in_ready = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/fpt_dp.sv
// datapath: queue, pointers, counts, frame builder, crc, link monitor, result word
`default_nettype none

module fpt_dp #(
  parameter int QUEUE_DEPTH  = fpt_pkg::QUEUE_DEPTH_DEF,
  parameter int PACKET_BYTES = fpt_pkg::PACKET_BYTES_DEF,
  parameter int MAX_PAYLOAD  = fpt_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic [1:0]                      in_cmd,
  input  wire logic [5:0]                      in_frame_length,
  input  wire logic [7:0]                      in_payload_byte,
  input  wire logic                            in_tx_ok,
  input  wire logic                            cfg_we,
  input  wire logic [fpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fpt_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  wire fpt_pkg::dp_cmd_t                cmd,
  output fpt_pkg::dp_stat_t                    stat,
  output fpt_pkg::out_word_t                   out_word
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int BL_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int PKT_W = $clog2(PACKET_BYTES + 1);

  // captured input word
  fpt_pkg::cmd_t cmd_r;
  logic [5:0]    len_r;
  logic [7:0]    byte_r;
  logic          ok_r;

  // queue and frame state
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] committed_r, committed_nxt;
  logic             open_r, open_nxt;
  logic [BL_W-1:0]  left_r, left_nxt;
  logic [7:0]       crc_r, crc_nxt;

  // packet and link state
  logic [PKT_W-1:0]              rem_r, rem_nxt;
  logic [fpt_pkg::HB_IDX_W-1:0]  hb_idx_r, hb_idx_nxt;
  logic [7:0]                    fail_r, fail_nxt;
  logic                          normal_r, normal_nxt;
  logic                          paired_r;
  logic [7:0]                    lost_limit_r;
  fpt_pkg::status_t              status_r;

  logic [7:0]       wr_data;
  logic [7:0]       rd_data;
  logic [PKT_W-1:0] pkt_n;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= fpt_pkg::cmd_t'(in_cmd);
      len_r  <= in_frame_length;
      byte_r <= in_payload_byte;
      ok_r   <= in_tx_ok;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  always_comb begin
    case (cmd.push_sel)
      fpt_pkg::PUSH_SOF:     wr_data = fpt_pkg::SOF_BYTE;
      fpt_pkg::PUSH_LEN_HI:  wr_data = 8'h00;
      fpt_pkg::PUSH_LEN_LO:  wr_data = {2'b00, len_r};
      fpt_pkg::PUSH_PAYLOAD: wr_data = byte_r;
      fpt_pkg::PUSH_CRC:     wr_data = crc_r;
      fpt_pkg::PUSH_EOF:     wr_data = fpt_pkg::EOF_BYTE;
      default:               wr_data = 8'h00;
    endcase
  end

  fpt_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .wr_en  (cmd.push_en),
    .wr_addr(wr_ptr_r),
    .wr_data(wr_data),
    .rd_en  (cmd.drain_read),
    .rd_addr(rd_ptr_r),
    .rd_data(rd_data)
  );

  assign pkt_n = (committed_r < CNT_W'(PACKET_BYTES)) ? PKT_W'(committed_r)
                                                     : PKT_W'(PACKET_BYTES);

  // queue bookkeeping
  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    used_nxt      = used_r;
    committed_nxt = committed_r;
    open_nxt      = open_r;
    left_nxt      = left_r;
    crc_nxt       = crc_r;
    if (cmd.push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      used_nxt   = used_r + 1'b1;
    end
    if (cmd.open_frame) begin
      open_nxt = 1'b1;
      left_nxt = BL_W'(len_r);
      crc_nxt  = 8'h00;
    end
    if (cmd.pay_step) begin
      left_nxt = left_r - 1'b1;
      crc_nxt  = fpt_pkg::crc8_update(crc_r, byte_r);
    end
    if (cmd.close_frame) begin
      // end byte goes in this cycle, so the frame is whole after it
      committed_nxt = used_r + 1'b1;
      open_nxt      = 1'b0;
      left_nxt      = '0;
      crc_nxt       = 8'h00;
    end
    if (cmd.drain_read) begin
      rd_ptr_nxt    = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      used_nxt      = used_r - 1'b1;
      committed_nxt = committed_r - 1'b1;
    end
  end

  // packet counters and link monitor
  always_comb begin
    rem_nxt    = rem_r;
    hb_idx_nxt = hb_idx_r;
    fail_nxt   = fail_r;
    normal_nxt = normal_r;
    if (cmd.drain_load) rem_nxt = pkt_n;
    if (cmd.drain_next) rem_nxt = rem_r - 1'b1;
    if (cmd.heart_clear) hb_idx_nxt = '0;
    if (cmd.heart_next) hb_idx_nxt = hb_idx_r + 1'b1;
    if (cmd.radio_update) begin
      if (ok_r) begin
        fail_nxt   = 8'h00;
        normal_nxt = 1'b1;
      end else if (fail_r < lost_limit_r) begin
        fail_nxt = fail_r + 1'b1;
      end else begin
        normal_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      used_r       <= '0;
      committed_r  <= '0;
      open_r       <= 1'b0;
      left_r       <= '0;
      crc_r        <= 8'h00;
      rem_r        <= '0;
      hb_idx_r     <= '0;
      fail_r       <= 8'h00;
      normal_r     <= 1'b0;
      paired_r     <= 1'b0;
      lost_limit_r <= fpt_pkg::LOST_LIMIT_RST;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      used_r      <= used_nxt;
      committed_r <= committed_nxt;
      open_r      <= open_nxt;
      left_r      <= left_nxt;
      crc_r       <= crc_nxt;
      rem_r       <= rem_nxt;
      hb_idx_r    <= hb_idx_nxt;
      fail_r      <= fail_nxt;
      normal_r    <= normal_nxt;
      if (cfg_we) begin
        unique case (fpt_pkg::reg_idx_t'(cfg_index))
          fpt_pkg::REG_PAIRED:     paired_r     <= cfg_data[0];
          fpt_pkg::REG_LOST_LIMIT: lost_limit_r <= cfg_data;
          default:                 paired_r     <= paired_r;
        endcase
      end
    end
  end

  always_comb begin
    stat.cmd         = cmd_r;
    stat.frame_open  = open_r;
    stat.too_long    = {1'b0, len_r} > 7'(MAX_PAYLOAD);
    stat.no_room     = (SUM_W'(used_r) + SUM_W'(len_r) + SUM_W'(fpt_pkg::FRAME_OVERHEAD))
                       > SUM_W'(QUEUE_DEPTH);
    stat.len_zero    = (len_r == 6'd0);
    stat.left_one    = (left_r == BL_W'(1));
    stat.paired      = paired_r;
    stat.queue_empty = (committed_r == '0);
    stat.drain_last  = (rem_r == PKT_W'(1));
    stat.heart_last  = (hb_idx_r == fpt_pkg::HEART_LAST);
  end

  always_comb begin
    out_word.signal_ok = normal_r;
    case (cmd.out_sel)
      fpt_pkg::OUT_HEART: begin
        out_word.kind       = 1'b1;
        out_word.radio_byte = fpt_pkg::heart_byte(hb_idx_r);
        out_word.last       = (hb_idx_r == fpt_pkg::HEART_LAST);
        out_word.heartbeat  = 1'b1;
        out_word.status     = fpt_pkg::ST_OK;
      end
      fpt_pkg::OUT_QUEUE: begin
        out_word.kind       = 1'b1;
        out_word.radio_byte = rd_data;
        out_word.last       = (rem_r == PKT_W'(1));
        out_word.heartbeat  = 1'b0;
        out_word.status     = fpt_pkg::ST_OK;
      end
      default: begin
        out_word.kind       = 1'b0;
        out_word.radio_byte = 8'h00;
        out_word.last       = 1'b0;
        out_word.heartbeat  = 1'b0;
        out_word.status     = status_r;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/framed_packet_transmitter_core.sv
// top level: framed packet transmitter core, controller plus datapath
// sequence: each accepted word other than a send is decoded, any queue writes of its frame follow,
//   then its status word is offered; one queue write per cycle
// packets: registered queue read, then output, per drained byte; heartbeat bytes output directly
// throughput: one word at a time; next word accepted once all results of the last are taken
// reset: synchronous active-low rst_n empties the queue, unpaired, link lost, lost_limit 150
`default_nettype none

module framed_packet_transmitter_core #(
  parameter int QUEUE_DEPTH  = fpt_pkg::QUEUE_DEPTH_DEF,
  parameter int PACKET_BYTES = fpt_pkg::PACKET_BYTES_DEF,
  parameter int MAX_PAYLOAD  = fpt_pkg::MAX_PAYLOAD_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fpt_in_if.sink    in_ch,
  fpt_out_if.source out_ch,
  fpt_cfg_if.sink   cfg_ch
);

  fpt_pkg::dp_cmd_t   dp_cmd;
  fpt_pkg::dp_stat_t  dp_stat;
  fpt_pkg::out_word_t out_word;

  // register writes are taken at any time; the user must write them only while idle, the block does not enforce it
  assign cfg_ch.ready = 1'b1;

  // sequencer: decode, frame writes, status and packet output
  fpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // queue memory, counters, crc and link monitor
  fpt_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_ch.cmd),
    .in_frame_length(in_ch.frame_length),
    .in_payload_byte(in_ch.payload_byte),
    .in_tx_ok       (in_ch.tx_ok),
    .cfg_we         (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .cmd            (dp_cmd),
    .stat           (dp_stat),
    .out_word       (out_word)
  );

  // result word fields
  assign out_ch.kind       = out_word.kind;
  assign out_ch.radio_byte = out_word.radio_byte;
  assign out_ch.last       = out_word.last;
  assign out_ch.heartbeat  = out_word.heartbeat;
  assign out_ch.status     = out_word.status;
  assign out_ch.signal_ok  = out_word.signal_ok;

  // one word in flight: never ready for input while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // a packet ends the sequence of results for its send tick
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("result offered after the final packet byte");

  // the closing heartbeat byte always carries last
  a_heart_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.heartbeat
     && out_ch.radio_byte == fpt_pkg::heart_byte(fpt_pkg::HEART_LAST)) |-> out_ch.last)
    else $error("heartbeat closing byte without last");

endmodule

`default_nettype wire
